@@ sv/tmw_pkg.sv @@
// Shared constants, item codes and the queue item type of the text-mode terminal writer.
package tmw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int FILL_W  = $clog2(COLUMNS + 1);
  localparam int ADDR_W  = $clog2(CELL_COUNT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'h07;

  // Request kinds decided by the front end.
  localparam logic [1:0] KIND_PUT     = 2'd0;
  localparam logic [1:0] KIND_NEWLINE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic              rd_in_range;
  } tmw_item_t;

endpackage

@@ sv/tmw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module tmw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/tmw_front.sv @@
// Front end: accepts requests, classifies them and holds them in a short queue.
module tmw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_operation,
  input  logic [tmw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tmw_pkg::ROW_W-1:0]   in_read_row,
  input  logic [tmw_pkg::COL_W-1:0]   in_read_col,
  output logic                        busy,
  output logic                        head_valid,
  output tmw_pkg::tmw_item_t          head,
  input  logic                        pop
);
  import tmw_pkg::*;

  tmw_item_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  tmw_item_t           item;
  logic                push;
  logic                in_range;

  assign busy       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push       = start && !busy;

  always_comb begin
    in_range = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
    if (in_operation) begin
      item.kind = KIND_READ;
    end else if (in_char_code == NEWLINE_CODE) begin
      item.kind = KIND_NEWLINE;
    end else begin
      item.kind = KIND_PUT;
    end
    item.char_code   = in_char_code;
    // Out-of-range reads carry a zero address so that later indexing stays inside the screen.
    item.rd_row      = in_range ? in_read_row : '0;
    item.rd_col      = in_range ? in_read_col : '0;
    item.rd_in_range = in_range;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ sv/tmw_back.sv @@
// Back end: cursor, circular row mapping, per-row fill counts, screen RAM and result register.
module tmw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tmw_pkg::ATTR_W-1:0]  text_color,
  input  logic                        head_valid,
  input  tmw_pkg::tmw_item_t          head,
  output logic                        pop,
  output logic                        out_strobe,
  output logic [tmw_pkg::CELL_W-1:0]  out_cell_value,
  output logic [tmw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tmw_pkg::COL_W-1:0]   out_cursor_col,
  output logic                        out_scrolled
);
  import tmw_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    base_r, base_nxt;
  logic [ROW_W-1:0]    cur_phys_r, cur_phys_nxt;
  logic [FILL_W-1:0]   fill_r [ROWS];

  logic                rd_ok_r;
  logic                rd_filled_r;

  logic                out_strobe_r, out_strobe_nxt;
  logic [CELL_W-1:0]   out_cell_r, out_cell_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                out_scrolled_r, out_scrolled_nxt;

  logic [FILL_W-1:0]   col_inc;
  logic                move_down;
  logic                scroll;
  logic                fill_set;
  logic [ROW_W:0]      rd_sum;
  logic [ROW_W-1:0]    rd_phys;
  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_filled;
  logic                ram_we;
  logic [CELL_W-1:0]   ram_rdata;

  assign pop = head_valid && (state_r == ST_IDLE);

  // Logical row r lives in physical row (base + r) mod ROWS, so a scroll is one pointer step.
  always_comb begin
    rd_sum    = {1'b0, base_r} + {1'b0, head.rd_row};
    rd_phys   = (32'(rd_sum) >= ROWS) ? ROW_W'(32'(rd_sum) - ROWS) : ROW_W'(rd_sum);
    rd_addr   = ADDR_W'(ADDR_W'(rd_phys) * ADDR_W'(COLUMNS)) + ADDR_W'(head.rd_col);
    cur_addr  = ADDR_W'(ADDR_W'(cur_phys_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);
    // Cells at or beyond a row's fill count have not been written since the row was blanked.
    rd_filled = (FILL_W'(head.rd_col) < fill_r[rd_phys]);
    col_inc   = FILL_W'(col_r) + 1'b1;
    ram_we    = pop && (head.kind == KIND_PUT);
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    base_nxt     = base_r;
    cur_phys_nxt = cur_phys_r;
    move_down    = 1'b0;
    scroll       = 1'b0;
    fill_set     = 1'b0;
    if (pop) begin
      case (head.kind)
        KIND_PUT: begin
          fill_set = 1'b1;
          if (col_inc == FILL_W'(COLUMNS)) begin
            col_nxt   = '0;
            move_down = 1'b1;
          end else begin
            col_nxt = COL_W'(col_inc);
          end
        end
        KIND_NEWLINE: begin
          col_nxt   = '0;
          move_down = 1'b1;
        end
        KIND_READ: begin
          state_nxt = ST_READ;
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_READ) begin
      state_nxt = ST_IDLE;
    end
    if (move_down) begin
      if (32'(row_r) == ROWS - 1) begin
        // The oldest physical row becomes the new, blank bottom row.
        scroll       = 1'b1;
        base_nxt     = (32'(base_r) == ROWS - 1) ? '0 : base_r + 1'b1;
        cur_phys_nxt = base_r;
      end else begin
        row_nxt      = row_r + 1'b1;
        cur_phys_nxt = (32'(cur_phys_r) == ROWS - 1) ? '0 : cur_phys_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_strobe_nxt   = 1'b0;
    out_cell_nxt     = '0;
    out_row_nxt      = row_nxt;
    out_col_nxt      = col_nxt;
    out_scrolled_nxt = scroll;
    if (state_r == ST_READ) begin
      out_strobe_nxt   = 1'b1;
      out_row_nxt      = row_r;
      out_col_nxt      = col_r;
      out_scrolled_nxt = 1'b0;
      if (rd_ok_r) begin
        out_cell_nxt = rd_filled_r ? ram_rdata : BLANK_CELL;
      end
    end else if (pop && (head.kind != KIND_READ)) begin
      out_strobe_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      cur_phys_r   <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      cur_phys_r   <= cur_phys_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (fill_set) begin
        fill_r[cur_phys_r] <= col_inc;
      end
      if (scroll) begin
        fill_r[base_r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_ok_r     <= head.rd_in_range;
      rd_filled_r <= rd_filled;
    end
    out_cell_r     <= out_cell_nxt;
    out_row_r      <= out_row_nxt;
    out_col_r      <= out_col_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  tmw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata ({text_color, head.char_code}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_strobe     = out_strobe_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scrolled_r;

endmodule

@@ sv/text_mode_terminal_writer.sv @@
// Top level of the text-mode terminal writer: colour register, front end and back end.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------------
//  in       start && !busy       in_operation, in_char_code, in_read_row, in_read_col
//  out      out_strobe (1 cycle) out_cell_value, out_cursor_row, out_cursor_col,
//                                out_scrolled
//  cfg      cfg_valid && ready   cfg_data (text colour attribute)
//
// A put or newline ends when popped; a read also passes through ST_READ, as the screen
// RAM read port is registered. A result appears the cycle after the back end is done.
// A two-entry request queue sits in front, so busy rises only when it is full.
// Scrolling costs nothing extra: it steps a row base pointer and zeroes one row fill count.
// Reset is synchronous and takes effect at once; there is no clearing pass over the RAM.
// Results cannot be held off: each is presented for exactly one cycle.
module text_mode_terminal_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [tmw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tmw_pkg::ROW_W-1:0]   in_read_row,
  input  logic [tmw_pkg::COL_W-1:0]   in_read_col,
  output logic                        out_strobe,
  output logic [tmw_pkg::CELL_W-1:0]  out_cell_value,
  output logic [tmw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tmw_pkg::COL_W-1:0]   out_cursor_col,
  output logic                        out_scrolled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tmw_pkg::ATTR_W-1:0]  cfg_data
);
  import tmw_pkg::*;

  logic [ATTR_W-1:0] text_color_r;
  logic              head_valid;
  tmw_item_t         head;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_color_r <= cfg_data;
    end
  end

  tmw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .busy         (busy),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  tmw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_color     (text_color_r),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_scrolled |->
      (32'(out_cursor_row) == ROWS - 1) && (out_cursor_col == '0))
    else $error("scroll reported with cursor away from the bottom row start");

  // Only reads return cell data, and reads never scroll.
  a_read_no_scroll : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_cell_value != '0) |-> !out_scrolled)
    else $error("result carries both cell data and a scroll");

  // The cursor reported with every result lies on the screen.
  a_cursor_on_screen : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_cursor_row) < ROWS) && (32'(out_cursor_col) < COLUMNS))
    else $error("cursor reported outside the screen");

  // The queue cannot be full without a request waiting for the back end.
  a_busy_has_head : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> head_valid)
    else $error("busy with an empty request queue");

endmodule

@@ tb/text_mode_terminal_writer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text-mode terminal writer: directed edges, then random text.
module text_mode_terminal_writer_tb;
  import tmw_pkg::*;

  localparam logic OP_PUT       = 1'b0;
  localparam logic OP_READ      = 1'b1;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } console_report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [CHAR_W-1:0] in_char_code;
  logic [ROW_W-1:0]  in_read_row;
  logic [COL_W-1:0]  in_read_col;
  logic              out_strobe;
  logic [CELL_W-1:0] out_cell_value;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic              out_scrolled;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data;

  // Our own copy of the screen, cursor and colour register.
  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ATTR_W-1:0] text_attr;

  console_report_t awaited_reports [$];
  console_report_t arrived_want;
  int              error_count;
  int              cycle_count;
  bit              gaps_off;

  text_mode_terminal_writer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
  endtask

  // Applies one accepted request to the screen copy and queues the report it should produce.
  task automatic step_console(input logic op, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    console_report_t rep;
    logic            next_line;
    rep       = '0;
    next_line = 1'b0;
    if (op == OP_READ) begin
      if (rr < ROWS && rc < COLUMNS) rep.cell_value = screen[rr * COLUMNS + rc];
    end else begin
      if (ch == NEWLINE_CODE) begin
        cur_col   = '0;
        next_line = 1'b1;
      end else begin
        screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
        if (cur_col == COLUMNS - 1) begin
          cur_col   = '0;
          next_line = 1'b1;
        end else begin
          cur_col++;
        end
      end
      if (next_line) begin
        if (cur_row == ROWS - 1) begin
          scroll_screen();
          rep.scrolled = 1'b1;
        end else begin
          cur_row++;
        end
      end
    end
    rep.cursor_row = cur_row;
    rep.cursor_col = cur_col;
    awaited_reports.push_back(rep);
  endtask

  // Presents one request, with an occasional idle gap first, and waits for it to be taken.
  task automatic send_request(input logic op, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    if (!gaps_off && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (busy);
    step_console(op, ch, rr, rc);
  endtask

  task automatic wait_console_idle();
    start <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_colour(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    text_attr = value;
  endtask

  // Mix of puts and reads; reads favour the cursor row so that fresh text is read back.
  task automatic send_text_mix(input int count, input int newline_pct, input int read_pct);
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    logic [CHAR_W-1:0] ch;
    int                pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < read_pct) begin
        pick = $urandom_range(9);
        if (pick < 2) begin
          rr = ROW_W'($urandom);
          rc = COL_W'($urandom);
        end else if (pick < 5) begin
          rr = cur_row;
          rc = COL_W'($urandom_range(COLUMNS - 1));
        end else begin
          rr = ROW_W'($urandom_range(ROWS - 1));
          rc = COL_W'($urandom_range(COLUMNS - 1));
        end
        send_request(OP_READ, CHAR_W'($urandom), rr, rc);
      end else begin
        ch = ($urandom_range(99) < newline_pct) ? NEWLINE_CODE : CHAR_W'($urandom);
        send_request(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
      end
    end
  endtask

  // Reset contents, out-of-range reads, extreme characters and newlines, with the reset colour.
  task automatic test_reset_and_edges();
    send_request(OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(OP_READ, 8'hFF, 5'd24, 7'd79);
    send_request(OP_READ, 8'h00, 5'd25, 7'd0);
    send_request(OP_READ, 8'h00, 5'd31, 7'd127);
    send_request(OP_READ, 8'h00, 5'd0, 7'd80);
    send_request(OP_READ, 8'h00, 5'd24, 7'd127);
    send_request(OP_PUT, 8'h41, 5'd31, 7'd127);
    send_request(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_request(OP_PUT, 8'hFF, 5'd24, 7'd79);
    send_request(OP_PUT, 8'h09, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h0B, 5'd0, 7'd0);
    send_request(OP_READ, NEWLINE_CODE, 5'd0, 7'd0);
    send_request(OP_READ, 8'hFF, 5'd0, 7'd1);
    send_request(OP_READ, 8'h55, 5'd0, 7'd2);
    send_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h7E, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd2, 7'd0);
    send_request(OP_READ, 8'h00, 5'd1, 7'd0);
    send_request(OP_READ, 8'h00, 5'd0, 7'd5);
    wait_console_idle();
  endtask

  // Long lines, so the cursor wraps at the row end.
  task automatic test_long_lines();
    write_text_colour(8'h00);
    send_text_mix(370, 1, 15);
    wait_console_idle();
  endtask

  // Ordinary text with no idle gaps at all, in the brightest colour.
  task automatic test_dense_text();
    write_text_colour(8'hFF);
    gaps_off = 1'b1;
    send_text_mix(370, 8, 25);
    gaps_off = 1'b0;
    wait_console_idle();
  endtask

  // Short lines scroll the screen often, including newlines on the bottom row.
  task automatic test_short_lines();
    write_text_colour(ATTR_W'($urandom));
    send_text_mix(370, 30, 30);
    wait_console_idle();
  endtask

  // Mostly reads across the whole screen after heavy scrolling.
  task automatic test_screen_readback();
    write_text_colour(ATTR_W'($urandom));
    send_text_mix(370, 10, 60);
    wait_console_idle();
  endtask

  task automatic test_reset_colour_again();
    write_text_colour(COLOR_RESET);
    send_text_mix(370, 12, 30);
    wait_console_idle();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_reports.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        arrived_want = awaited_reports.pop_front();
        if (out_cell_value !== arrived_want.cell_value) begin
          $error("cell_value: expected %h, got %h", arrived_want.cell_value, out_cell_value);
          error_count++;
        end
        if (out_cursor_row !== arrived_want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", arrived_want.cursor_row, out_cursor_row);
          error_count++;
        end
        if (out_cursor_col !== arrived_want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", arrived_want.cursor_col, out_cursor_col);
          error_count++;
        end
        if (out_scrolled !== arrived_want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", arrived_want.scrolled, out_scrolled);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_PUT;
    in_char_code = '0;
    in_read_row  = '0;
    in_read_col  = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    error_count  = 0;
    cycle_count  = 0;
    gaps_off     = 1'b0;
    cur_row      = '0;
    cur_col      = '0;
    text_attr    = COLOR_RESET;
    for (int i = 0; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_edges();
    test_long_lines();
    test_dense_text();
    test_short_lines();
    test_screen_readback();
    test_reset_colour_again();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tmw_pkg.sv
sv/tmw_ram.sv
sv/tmw_front.sv
sv/tmw_back.sv
sv/text_mode_terminal_writer.sv
tb/text_mode_terminal_writer_tb.sv
